FILE: hw/rtl/wrsa_pkg.sv
// Shared types, constants and helpers for the wraparound ring span allocator.
`timescale 1ns / 1ps
`default_nettype none
package wrsa_pkg;

  localparam int SIZE_W   = 17;
  localparam int OFS_W    = 16;
  localparam int STATUS_W = 2;

  localparam int PENDING_DEPTH_DEF = 8;
  localparam int OFFSET_BITS_DEF   = 16;

  localparam logic [SIZE_W-1:0] CAP_RESET = 17'd32768;
  localparam logic [SIZE_W-1:0] CAP_MAX   = 17'd65536;
  localparam logic [SIZE_W-1:0] CAP_MIN   = 17'd1;

  localparam logic MODE_RESERVE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_DEFER   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input transaction
    logic exec;   // run reserve or release
    logic wrap;   // fold start back to zero at the wrap mark
    logic scan;   // retire one pending entry sitting at start
    logic fin;    // load result register, empty-buffer reset
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_rel; // release lands at start
    logic hit;      // a pending entry starts at start
  } dp_stat_t;

  // out-of-range capacities saturate into 1..65536
  function automatic logic [SIZE_W-1:0] clamp_cap(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = CAP_MIN;
    else if (v > CAP_MAX) r = CAP_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/wrsa_in_if.sv
// Request channel interface: reserve/release transactions.
`timescale 1ns / 1ps
`default_nettype none
interface wrsa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [wrsa_pkg::SIZE_W-1:0]  span_size;
  logic [wrsa_pkg::OFS_W-1:0]   span_offset;

  modport source (output valid, output mode, output span_size, output span_offset,
                  input ready);
  modport sink   (input valid, input mode, input span_size, input span_offset,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wrsa_out_if.sv
// Result channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface wrsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [wrsa_pkg::STATUS_W-1:0]  status;
  logic [wrsa_pkg::OFS_W-1:0]     granted_offset;
  logic                           is_empty;

  modport source (output valid, output status, output granted_offset, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input granted_offset, input is_empty,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wrsa_cfg_if.sv
// Configuration write channel interface (buffer capacity).
`timescale 1ns / 1ps
`default_nettype none
interface wrsa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wrsa_pkg::SIZE_W-1:0]  buffer_bytes;

  modport source (output valid, output buffer_bytes, input ready);
  modport sink   (input valid, input buffer_bytes, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wraparound_ring_span_allocator.sv
// Top level of the wraparound ring span allocator.
//
//  channel  | role   | payload                                   | accept
//  ---------+--------+-------------------------------------------+-------------
//  in_ch    | sink   | mode, span_size, span_offset              | valid&ready
//  out_ch   | source | status, granted_offset, is_empty          | valid&ready
//  cfg_ch   | sink   | buffer_bytes (capacity)                   | valid&ready
//
//  Steps: a reserve, or a release that does not land at start, goes through
//    capture, execute and result load; the result load waits while the
//    previous result is still held and not taken.
//  A release at start adds wrap and scan steps, one pair per pass, one pass
//    per pending entry retired plus a final one; the retire loop checks the
//    wrap mark and then the pending table, one entry per pass.
//  Reset (rst_n, synchronous) clears marks and pending valid bits at once;
//    capacity returns to 32768. No clearing pass.
//  Results sit in an output register; a new transaction is taken while the
//    previous result waits, and the block holds in its last step only when
//    the result register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
module wraparound_ring_span_allocator #(
  parameter int PENDING_DEPTH = wrsa_pkg::PENDING_DEPTH_DEF,
  parameter int OFFSET_BITS   = wrsa_pkg::OFFSET_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wrsa_in_if.sink     in_ch,
  wrsa_out_if.source  out_ch,
  wrsa_cfg_if.sink    cfg_ch
);

  wrsa_pkg::ctrl_cmd_t cmd;
  wrsa_pkg::dp_stat_t  st;

  // the user must send capacity writes only while idle; the block always takes them unchecked
  assign cfg_ch.ready = 1'b1;

  wrsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  wrsa_dp #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.buffer_bytes),
    .in_mode    (in_ch.mode),
    .in_size    (in_ch.span_size),
    .in_off     (in_ch.span_offset),
    .cmd        (cmd),
    .st         (st),
    .out_status (out_ch.status),
    .out_ofs    (out_ch.granted_offset),
    .out_empty  (out_ch.is_empty)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/wrsa_ctrl.sv
// Sequencing state machine for the span allocator.
`timescale 1ns / 1ps
`default_nettype none
module wrsa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire wrsa_pkg::dp_stat_t   st,
  output wrsa_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WRAP = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fin       = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = st.head_rel ? S_WRAP : S_DONE;
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = st.hit ? S_WRAP : S_DONE;
      end
      S_DONE: begin
        cmd.fin = fin;
        if (fin) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = fin || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("result not presented after finish");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_EXEC))
    else $error("accepted transaction did not execute");

  a_hit_rescans: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && st.hit) |=> (state_r == S_WRAP))
    else $error("retire did not loop back");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/wrsa_dp.sv
// Datapath: marks, pending table, capacity register and result register.
`timescale 1ns / 1ps
`default_nettype none
module wrsa_dp #(
  parameter int PENDING_DEPTH = wrsa_pkg::PENDING_DEPTH_DEF,
  parameter int OFFSET_BITS   = wrsa_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wrsa_pkg::SIZE_W-1:0]       cfg_data,
  input  wire logic                              in_mode,
  input  wire logic [wrsa_pkg::SIZE_W-1:0]       in_size,
  input  wire logic [wrsa_pkg::OFS_W-1:0]        in_off,
  input  wire wrsa_pkg::ctrl_cmd_t               cmd,
  output wrsa_pkg::dp_stat_t                     st,
  output logic [wrsa_pkg::STATUS_W-1:0]          out_status,
  output logic [wrsa_pkg::OFS_W-1:0]             out_ofs,
  output logic                                   out_empty
);

  localparam int SW     = wrsa_pkg::SIZE_W;
  localparam int OW     = wrsa_pkg::OFS_W;
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CMP_W  = (OFFSET_BITS > SW) ? OFFSET_BITS : SW;

  logic [SW-1:0]          cap_r, cap_nxt;
  logic [SW-1:0]          head_r, head_nxt;
  logic [SW-1:0]          tail_r, tail_nxt;
  logic [SW-1:0]          wrap_r, wrap_nxt;
  logic [PENDING_DEPTH-1:0] pvalid_r, pvalid_nxt;
  logic [OFFSET_BITS-1:0] poff_r [PENDING_DEPTH];
  logic [OFFSET_BITS-1:0] poff_nxt [PENDING_DEPTH];
  logic [SW-1:0]          plen_r [PENDING_DEPTH];
  logic [SW-1:0]          plen_nxt [PENDING_DEPTH];

  logic                   mode_r, mode_nxt;
  logic [SW-1:0]          size_r, size_nxt;
  logic [OW-1:0]          off_r, off_nxt;

  wrsa_pkg::status_t      res_status_r, res_status_nxt;
  logic [OW-1:0]          res_ofs_r, res_ofs_nxt;
  logic                   chk_clr_r, chk_clr_nxt;
  logic [wrsa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OW-1:0]          out_ofs_r, out_ofs_nxt;
  logic                   out_empty_r, out_empty_nxt;

  // pending table lookups
  logic                   hit, free_found;
  logic [PIDX_W-1:0]      hit_idx, free_idx;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (!hit && pvalid_r[i] && (CMP_W'(poff_r[i]) == CMP_W'(head_r))) begin
        hit     = 1'b1;
        hit_idx = PIDX_W'(i);
      end
      if (!free_found && !pvalid_r[i]) begin
        free_found = 1'b1;
        free_idx   = PIDX_W'(i);
      end
    end
  end

  logic [SW-1:0]    off17;
  logic [SW:0]      end_sum;
  logic [SW-1:0]    tail_sum, tail_sub, head_add;
  logic             tail_fits;
  logic [CMP_W-1:0] off_ext;

  assign off17     = SW'(off_r);
  assign end_sum   = {1'b0, off17} + {1'b0, size_r};
  assign tail_sum  = tail_r + size_r;
  assign tail_sub  = tail_r - size_r;
  assign head_add  = head_r + size_r;
  assign tail_fits = (tail_r <= cap_r) && ((cap_r - tail_r) >= size_r);
  assign off_ext   = CMP_W'(off_r);

  assign st.head_rel = (mode_r == wrsa_pkg::MODE_RELEASE) && (off17 == head_r);
  assign st.hit      = hit;

  always_comb begin
    cap_nxt        = cfg_we ? wrsa_pkg::clamp_cap(cfg_data) : cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    wrap_nxt       = wrap_r;
    pvalid_nxt     = pvalid_r;
    poff_nxt       = poff_r;
    plen_nxt       = plen_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    off_nxt        = off_r;
    res_status_nxt = res_status_r;
    res_ofs_nxt    = res_ofs_r;
    chk_clr_nxt    = chk_clr_r;
    out_status_nxt = out_status_r;
    out_ofs_nxt    = out_ofs_r;
    out_empty_nxt  = out_empty_r;

    if (cmd.load) begin
      mode_nxt = in_mode;
      size_nxt = in_size;
      off_nxt  = in_off;
    end

    if (cmd.exec) begin
      res_ofs_nxt    = '0;
      chk_clr_nxt    = 1'b0;
      res_status_nxt = wrsa_pkg::ST_OK;
      if (mode_r == wrsa_pkg::MODE_RESERVE) begin
        if (|pvalid_r) begin
          res_status_nxt = wrsa_pkg::ST_NO_ROOM;
        end else if (head_r == tail_r) begin
          if (size_r > cap_r) begin
            res_status_nxt = wrsa_pkg::ST_NO_ROOM;
          end else begin
            head_nxt = '0;
            tail_nxt = size_r;
            wrap_nxt = size_r;
          end
        end else if (tail_r > head_r) begin
          if (tail_fits) begin
            res_ofs_nxt = tail_r[OW-1:0];
            tail_nxt    = tail_sum;
            wrap_nxt    = tail_sum;
          end else if (head_r >= size_r) begin
            tail_nxt = size_r;   // wrap to offset zero, granted at 0
          end else begin
            res_status_nxt = wrsa_pkg::ST_NO_ROOM;
          end
        end else if ((head_r - tail_r) >= size_r) begin
          res_ofs_nxt = tail_r[OW-1:0];
          tail_nxt    = tail_sum;
        end else begin
          res_status_nxt = wrsa_pkg::ST_NO_ROOM;
        end
      end else begin
        if (off17 == head_r) begin
          head_nxt    = head_add;
          chk_clr_nxt = 1'b1;
        end else if (end_sum == {1'b0, tail_r}) begin
          chk_clr_nxt = 1'b1;
          if (tail_r == wrap_r) begin
            tail_nxt = tail_sub;
            wrap_nxt = wrap_r - size_r;
          end else begin
            tail_nxt = (tail_sub == '0) ? wrap_r : tail_sub;
          end
        end else if (free_found) begin
          pvalid_nxt[free_idx] = 1'b1;
          poff_nxt[free_idx]   = off_ext[OFFSET_BITS-1:0];
          plen_nxt[free_idx]   = size_r;
          res_status_nxt       = wrsa_pkg::ST_DEFER;
        end else begin
          res_status_nxt = wrsa_pkg::ST_FULL;
        end
      end
    end

    if (cmd.wrap) begin
      if (head_r != tail_r && head_r == wrap_r) begin
        wrap_nxt = tail_r;
        head_nxt = '0;
      end
    end

    if (cmd.scan && hit) begin
      pvalid_nxt[hit_idx] = 1'b0;
      head_nxt            = head_r + plen_r[hit_idx];
    end

    if (cmd.fin) begin
      out_status_nxt = res_status_r;
      out_ofs_nxt    = res_ofs_r;
      out_empty_nxt  = (head_r == tail_r);
      if (chk_clr_r && head_r == tail_r) begin
        head_nxt   = '0;
        tail_nxt   = '0;
        wrap_nxt   = '0;
        pvalid_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= wrsa_pkg::CAP_RESET;
      head_r   <= '0;
      tail_r   <= '0;
      wrap_r   <= '0;
      pvalid_r <= '0;
    end else begin
      cap_r    <= cap_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      wrap_r   <= wrap_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    poff_r       <= poff_nxt;
    plen_r       <= plen_nxt;
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    off_r        <= off_nxt;
    res_status_r <= res_status_nxt;
    res_ofs_r    <= res_ofs_nxt;
    chk_clr_r    <= chk_clr_nxt;
    out_status_r <= out_status_nxt;
    out_ofs_r    <= out_ofs_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_status = out_status_r;
  assign out_ofs    = out_ofs_r;
  assign out_empty  = out_empty_r;

endmodule
`default_nettype wire

FILE: verif/wrsa_checker.sv
// Span allocator checker: tracks the ring state and compares every result transaction.
`timescale 1ns / 1ps
module wrsa_checker (
  input  logic              clk,
  input  logic              rst_n,
  wrsa_in_if                in_ch,
  wrsa_out_if               out_ch,
  wrsa_cfg_if               cfg_ch,
  output logic [16:0]       model_start,
  output logic [16:0]       model_cursor,
  output logic              model_busy,
  output wrsa_pkg::status_t last_status,
  output logic [15:0]       last_grant,
  output int                awaiting,
  output int                fault_count
);
  import wrsa_pkg::*;

  localparam int DEPTH = PENDING_DEPTH_DEF;

  typedef struct {
    status_t     status;
    logic [15:0] grant;
    logic        empty;
  } span_reply_t;

  logic [16:0] ring_cap;
  logic [16:0] ring_start;
  logic [16:0] ring_cursor;
  logic [16:0] ring_wrap;
  logic [15:0] defer_ofs [DEPTH];
  logic [16:0] defer_len [DEPTH];
  logic        defer_vld [DEPTH];
  span_reply_t replies_due [$];

  function automatic void wipe_ring();
    ring_start  = '0;
    ring_cursor = '0;
    ring_wrap   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      defer_ofs[i] = '0;
      defer_len[i] = '0;
      defer_vld[i] = 1'b0;
    end
  endfunction

  function automatic logic table_in_use();
    logic any;
    any = 1'b0;
    for (int i = 0; i < DEPTH; i++) any |= defer_vld[i];
    return any;
  endfunction

  // reserve: append after the cursor, or wrap to zero ahead of start
  function automatic status_t take_span(input logic [16:0] size, output logic [16:0] grant);
    logic [31:0] cap;
    cap   = (ring_cap == '0) ? 32'd1 : (ring_cap > 17'd65536) ? 32'd65536 : 32'(ring_cap);
    grant = '0;
    if (table_in_use()) return ST_NO_ROOM;
    if (ring_start == ring_cursor) begin
      if (32'(size) > cap) return ST_NO_ROOM;
      ring_start  = '0;
      ring_cursor = size;
      ring_wrap   = size;
      return ST_OK;
    end
    if (ring_cursor > ring_start) begin
      if (32'(ring_cursor) <= cap && cap - 32'(ring_cursor) >= 32'(size)) begin
        grant       = ring_cursor;
        ring_cursor = ring_cursor + size;
        ring_wrap   = ring_cursor;
        return ST_OK;
      end
      if (ring_start >= size) begin
        ring_cursor = size;
        return ST_OK;
      end
      return ST_NO_ROOM;
    end
    if (ring_start - ring_cursor >= size) begin
      grant       = ring_cursor;
      ring_cursor = ring_cursor + size;
      return ST_OK;
    end
    return ST_NO_ROOM;
  endfunction

  // release: advance start (retiring deferred spans), shrink the end, or defer
  function automatic status_t free_span(input logic [16:0] size, input logic [15:0] ofs);
    int  slot;
    int  n;
    int  i;
    logic done;
    if ({1'b0, ofs} == ring_start) begin
      ring_start = ring_start + size;
      done = 1'b0;
      for (n = 0; n <= DEPTH && !done; n++) begin
        if (ring_start != ring_cursor && ring_start == ring_wrap) begin
          ring_wrap  = ring_cursor;
          ring_start = '0;
        end
        slot = -1;
        for (i = 0; i < DEPTH; i++)
          if (slot < 0 && defer_vld[i] && {1'b0, defer_ofs[i]} == ring_start) slot = i;
        if (slot < 0) begin
          done = 1'b1;
        end else begin
          defer_vld[slot] = 1'b0;
          ring_start = ring_start + defer_len[slot];
        end
      end
    end else if (32'(ofs) + 32'(size) == 32'(ring_cursor)) begin
      if (ring_cursor == ring_wrap) begin
        ring_cursor = ring_cursor - size;
        ring_wrap   = ring_wrap - size;
      end else begin
        ring_cursor = ring_cursor - size;
        if (ring_cursor == '0) ring_cursor = ring_wrap;
      end
    end else begin
      for (i = 0; i < DEPTH; i++) begin
        if (!defer_vld[i]) begin
          defer_vld[i] = 1'b1;
          defer_ofs[i] = ofs;
          defer_len[i] = size;
          return ST_DEFER;
        end
      end
      return ST_FULL;
    end
    if (ring_start == ring_cursor) wipe_ring();
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    span_reply_t want;
    logic [16:0] grant;
    status_t     st;
    if (!rst_n) begin
      ring_cap = CAP_RESET;
      wipe_ring();
      replies_due.delete();
      fault_count = 0;
      last_status = ST_OK;
      last_grant  = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) ring_cap = cfg_ch.buffer_bytes;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_RESERVE) begin
          st = take_span(in_ch.span_size, grant);
        end else begin
          st    = free_span(in_ch.span_size, in_ch.span_offset);
          grant = '0;
        end
        want.status = st;
        want.grant  = (st == ST_OK && in_ch.mode == MODE_RESERVE) ? grant[15:0] : '0;
        want.empty  = (ring_start == ring_cursor);
        replies_due.push_back(want);
        last_status = st;
        last_grant  = want.grant;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          if (fault_count < 10)
            $display("%0t: unexpected result status %0d grant %0d empty %0b", $realtime,
                     out_ch.status, out_ch.granted_offset, out_ch.is_empty);
          fault_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_ch.status != want.status || out_ch.granted_offset != want.grant ||
              out_ch.is_empty != want.empty) begin
            if (fault_count < 10)
              $display("%0t: result mismatch: expected status %0d grant %0d empty %0b, got %0d %0d %0b",
                       $realtime, want.status, want.grant, want.empty,
                       out_ch.status, out_ch.granted_offset, out_ch.is_empty);
            fault_count++;
          end
        end
      end
    end
    model_start  = ring_start;
    model_cursor = ring_cursor;
    model_busy   = (ring_start != ring_cursor) || table_in_use();
    awaiting     = replies_due.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the span allocator: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb;
  import wrsa_pkg::*;

  typedef struct {
    logic [15:0] ofs;
    logic [16:0] len;
  } held_span_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // stimulus <-> receiver coordination
  logic rsp_hold = 1'b0;   // request one long receiver hold-off
  logic steady   = 1'b0;   // no idling on either side while set

  logic [16:0] model_start;
  logic [16:0] model_cursor;
  logic        model_busy;
  status_t     last_status;
  logic [15:0] last_grant;
  int          awaiting;
  int          fault_count;

  int          items_sent = 0;
  int          cur_cap    = 32768;   // effective capacity, as the block clamps it
  held_span_t  held [$];             // spans granted and not yet handed back

  wrsa_in_if  req_if ();
  wrsa_out_if rsp_if ();
  wrsa_cfg_if cap_if ();

  wraparound_ring_span_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if),
    .cfg_ch (cap_if)
  );

  wrsa_checker i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (req_if),
    .out_ch       (rsp_if),
    .cfg_ch       (cap_if),
    .model_start  (model_start),
    .model_cursor (model_cursor),
    .model_busy   (model_busy),
    .last_status  (last_status),
    .last_grant   (last_grant),
    .awaiting     (awaiting),
    .fault_count  (fault_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // One request transaction. Entered and left at a falling edge; valid stays
  // high on return so a back-to-back transaction needs no toggle. The
  // checker has already absorbed the transaction when this returns.
  task automatic push_request(input logic mode, input logic [16:0] size,
                              input logic [15:0] ofs);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.mode        = mode;
    req_if.span_size   = size;
    req_if.span_offset = ofs;
    req_if.valid       = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic settle();
    req_if.valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic write_capacity(input logic [16:0] value);
    settle();
    cap_if.buffer_bytes = value;
    cap_if.valid        = 1'b1;
    do @(posedge clk); while (!cap_if.ready);
    @(negedge clk);
    cap_if.valid = 1'b0;
    cur_cap = (value == '0) ? 1 : (value > 17'd65536) ? 65536 : int'(value);
  endtask

  // Hand back a held span; a release dropped on a full table stays held.
  task automatic release_held(input int idx);
    held_span_t s;
    s = held[idx];
    held.delete(idx);
    push_request(MODE_RELEASE, s.len, s.ofs);
    if (last_status == ST_FULL) held.push_back(s);
  endtask

  // Release from start up to the cursor: empties the ring and, with it, the
  // deferred table. Up to four tries cover a deferred span sitting at the
  // cursor; a start beyond the offset field falls back to cutting the end.
  task automatic flush_ring();
    int tries;
    for (tries = 0; tries < 4 && model_busy; tries++) begin
      if (model_start[16]) push_request(MODE_RELEASE, model_cursor, 16'd0);
      else push_request(MODE_RELEASE, model_cursor - model_start, model_start[15:0]);
    end
    held.delete();
  endtask

  // A burst of well-formed reserve/release traffic with a little noise,
  // then everything handed back in random order so deferred spans retire.
  task automatic run_episode(input int len);
    int          pick;
    int          k;
    logic [16:0] size;
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (held.size() == 0 || pick < 45) begin
        k = $urandom_range(0, 99);
        if (k < 70) size = 17'($urandom_range(1, cur_cap / 8 + 1));
        else if (k < 90) size = 17'($urandom_range(0, cur_cap));
        else size = 17'($urandom_range(0, 131071));
        push_request(MODE_RESERVE, size, 16'($urandom));
        if (last_status == ST_OK && size != '0) held.push_back('{last_grant, size});
      end else if (pick < 62) begin
        release_held(0);                               // oldest: at start
      end else if (pick < 78) begin
        release_held(held.size() - 1);                 // newest: at the cursor
      end else if (pick < 93) begin
        release_held($urandom_range(0, held.size() - 1));   // usually deferred
      end else if (pick < 97) begin
        push_request(MODE_RELEASE, 17'($urandom_range(0, 131071)), 16'($urandom));
      end else begin
        // odd-length release at start knocks the marks off the span grid
        push_request(MODE_RELEASE, 17'($urandom_range(0, 64)), model_start[15:0]);
      end
    end
    for (k = 0; k < 40 && held.size() != 0; k++)
      release_held($urandom_range(0, held.size() - 1));
    flush_ring();
  endtask

  // Receiver: random stall per result, plus one long hold-off on request so
  // the block fills and pushes back on the request side.
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    wait (rst_n == 1'b1);
    @(negedge clk);
    forever begin
      if (rsp_hold) begin
        rsp_if.ready = 1'b0;
        repeat (300) @(negedge clk);
        rsp_hold = 1'b0;
      end
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    int          p;
    int          k;
    int          phase_end;
    logic [16:0] cap_val;
    logic        hold_done;

    req_if.valid        = 1'b0;
    req_if.mode         = MODE_RESERVE;
    req_if.span_size    = '0;
    req_if.span_offset  = '0;
    cap_if.valid        = 1'b0;
    cap_if.buffer_bytes = '0;
    hold_done           = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset capacity 32768 ---
    // release on an empty ring with every field bit set gets deferred,
    // then fill the deferred table until it overflows
    push_request(MODE_RELEASE, 17'd131071, 16'd65535);
    for (k = 0; k < 8; k++) push_request(MODE_RELEASE, 17'd1, 16'(100 + k));
    push_request(MODE_RESERVE, 17'd100, 16'd0);          // refused while deferred
    push_request(MODE_RELEASE, 17'd0, 16'd0);            // empties, table cleared
    // out-of-order release, then a release at start retires it
    push_request(MODE_RESERVE, 17'd1000, 16'd0);
    push_request(MODE_RESERVE, 17'd2000, 16'd0);
    push_request(MODE_RESERVE, 17'd3000, 16'd0);
    push_request(MODE_RELEASE, 17'd2000, 16'd1000);
    push_request(MODE_RELEASE, 17'd1000, 16'd0);
    push_request(MODE_RELEASE, 17'd3000, 16'd3000);

    // capacity above range acts as 65536: fill, then zero-length at the very end
    write_capacity(17'd131071);
    push_request(MODE_RESERVE, 17'd65536, 16'd0);
    push_request(MODE_RESERVE, 17'd0, 16'd0);
    push_request(MODE_RELEASE, 17'd65536, 16'd0);

    // capacity zero acts as one
    write_capacity(17'd0);
    push_request(MODE_RESERVE, 17'd1, 16'd0);
    push_request(MODE_RESERVE, 17'd1, 16'd0);            // larger than the space
    push_request(MODE_RELEASE, 17'd1, 16'd0);

    // capacity lowered under a live cursor: the tail has no room, wrap to zero
    write_capacity(17'd32768);
    push_request(MODE_RESERVE, 17'd20000, 16'd0);
    push_request(MODE_RESERVE, 17'd5000, 16'd0);
    push_request(MODE_RELEASE, 17'd20000, 16'd0);
    write_capacity(17'd100);
    push_request(MODE_RESERVE, 17'd50, 16'd0);
    push_request(MODE_RELEASE, 17'd5000, 16'd20000);     // start hits the wrap mark
    push_request(MODE_RELEASE, 17'd50, 16'd0);

    // --- random phases, one capacity setting each ---
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       cap_val = 17'd65536;
        1:       cap_val = 17'($urandom_range(16, 600));
        2:       cap_val = 17'd32768;
        3:       cap_val = 17'($urandom_range(1, 65536));
        4:       cap_val = 17'd1;
        default: cap_val = 17'($urandom);
      endcase
      write_capacity(cap_val);
      phase_end = items_sent + 222;
      while (items_sent < phase_end) begin
        steady = ($urandom_range(0, 3) == 0);
        // long receiver hold-off while requests keep coming
        if (p == 1 && !hold_done && items_sent > phase_end - 180) begin
          steady    = 1'b1;
          rsp_hold  = 1'b1;
          hold_done = 1'b1;
        end
        run_episode($urandom_range(8, 48));
        // sender pause until the pipe is empty, at random mid-phase
        if (p == 2 && $urandom_range(0, 7) == 0) settle();
      end
    end
    steady = 1'b0;

    settle();
    repeat (30) @(negedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
